FILE: design/fst_pkg.sv
// Shared types, widths, field offsets and reset values for the flight statistics tracker.
`timescale 1ns / 1ps

package fst_pkg;

    // Default build parameters.
    localparam int SEARCH_DIVIDE_DEF = 5;
    localparam int ACC_WIDTH_DEF     = 40;

    // Input field widths.
    localparam int SPEED_W = 16;
    localparam int THR_W   = 7;
    localparam int ALT_W   = 16;
    localparam int HDG_W   = 9;
    localparam int DIST_W  = 16;
    localparam int CURR_W  = 16;
    localparam int TIME_W  = 32;
    localparam int DIR_W   = 12;
    localparam int DACC_W  = 32;

    // Input beat layout, lowest bit first.
    localparam int IN_GS_LSB    = 0;
    localparam int IN_AS_LSB    = 16;
    localparam int IN_THR_LSB   = 32;
    localparam int IN_ALT_LSB   = 39;
    localparam int IN_HDG_LSB   = 55;
    localparam int IN_HDIST_LSB = 64;
    localparam int IN_HALT_LSB  = 80;
    localparam int IN_LOCK_LSB  = 96;
    localparam int IN_CURR_LSB  = 97;
    localparam int IN_TIME_LSB  = 113;
    localparam int IN_BITS      = 145;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    // Output beat layout for the fields up to the first charge sum.
    localparam int OUT_FLY_LSB   = 0;
    localparam int OUT_DIR_LSB   = 1;
    localparam int OUT_PAIR_LSB  = 13;
    localparam int OUT_PGND_LSB  = 29;
    localparam int OUT_PALT_LSB  = 45;
    localparam int OUT_PDIST_LSB = 61;
    localparam int OUT_PHALT_LSB = 77;
    localparam int OUT_PCURR_LSB = 93;
    localparam int OUT_DACC_LSB  = 109;
    localparam int OUT_FCH_LSB   = 141;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAND_THR     = 3'd0,
        CFG_LAND_AS      = 3'd1,
        CFG_LAND_DIST    = 3'd2,
        CFG_LAND_ALT     = 3'd3,
        CFG_LAUNCH_THR   = 3'd4,
        CFG_LAUNCH_AS    = 3'd5,
        CFG_LAUNCH_ALT   = 3'd6
    } cfg_idx_t;

    // Threshold reset values.
    localparam logic [THR_W-1:0]   LAND_THR_RST   = 7'd5;
    localparam logic [15:0]        LAND_AS_RST    = 16'd50;
    localparam logic [15:0]        LAND_DIST_RST  = 16'd50;
    localparam logic [14:0]        LAND_ALT_RST   = 15'd10;
    localparam logic [THR_W-1:0]   LAUNCH_THR_RST = 7'd10;
    localparam logic [15:0]        LAUNCH_AS_RST  = 16'd50;
    localparam logic [15:0]        LAUNCH_ALT_RST = 16'd5;

    // Launch heading value meaning no launch recorded.
    localparam logic [DIR_W-1:0] NO_DIR = 12'hfff;

endpackage

FILE: design/flight_stats_tracker.sv
// Top level of the flight statistics tracker: input register, state update and result beat.
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_axis    in         one telemetry tick (fields listed at the port)
// m_axis    out        statistics after that tick (fields listed at the port)
// cfg       in         threshold write: register index and data
//
// Each tick passes from input beat to result beat through the input register,
// then through the compare and accumulate logic into the state and result
// registers. One tick is accepted per clock when the result side keeps up.
// A stall on m_axis holds the result register and the input register; s_axis
// tready drops only while both are full. cfg is always ready.
// rst_n clears all state to searching mode with the threshold defaults.

module flight_stats_tracker #(
    parameter int SEARCH_DIVIDE = fst_pkg::SEARCH_DIVIDE_DEF,
    parameter int ACC_WIDTH     = fst_pkg::ACC_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // ground_speed[15:0], air_speed[31:16], throttle_pct[38:32],
    // baro_altitude[54:39], heading_deg[63:55], home_distance[79:64],
    // home_altitude[95:80], home_fix[96], battery_current[112:97],
    // time_ms[144:113], zero fill above
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [fst_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // flying[0], launch_dir[12:1], peak_air_speed[28:13], peak_ground_speed[44:29],
    // peak_altitude[60:45], peak_home_distance[76:61], peak_home_altitude[92:77],
    // peak_current[108:93], distance_cm[140:109], flight_charge_sum,
    // total_charge_sum (ACC_WIDTH bits each), flight_duration_ms (32), zero fill
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((173 + 2*ACC_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fst_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fst_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import fst_pkg::*;

    localparam int PHASE_W   = (SEARCH_DIVIDE > 1) ? $clog2(SEARCH_DIVIDE) : 1;
    localparam int OUT_TCH_LSB = OUT_FCH_LSB + ACC_WIDTH;
    localparam int OUT_DUR_LSB = OUT_TCH_LSB + ACC_WIDTH;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SEARCH_DIVIDE - 1);

    // Saturating add of one signed current sample into a charge sum.
    function automatic logic signed [ACC_WIDTH-1:0] acc_add(
        input logic signed [ACC_WIDTH-1:0] acc,
        input logic signed [CURR_W-1:0]    x
    );
        logic signed [ACC_WIDTH:0] sum;
        sum = {acc[ACC_WIDTH-1], acc} + (ACC_WIDTH+1)'(x);
        if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1])
        begin
            acc_add = sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                     : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        else
        begin
            acc_add = sum[ACC_WIDTH-1:0];
        end
    endfunction

    // Threshold registers.
    logic [THR_W-1:0]         land_thr_reg;
    logic [15:0]              land_as_reg;
    logic [15:0]              land_dist_reg;
    logic [14:0]              land_alt_reg;
    logic [THR_W-1:0]         launch_thr_reg;
    logic [15:0]              launch_as_reg;
    logic signed [15:0]       launch_alt_reg;

    // Input register.
    logic                     in_valid_reg;
    logic [IN_BITS-1:0]       in_data_reg;

    // Tracker state.
    logic                     flying_reg, flying_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic [DIR_W-1:0]         dir_reg, dir_next;
    logic [SPEED_W-1:0]       max_air_reg, max_air_next;
    logic [SPEED_W-1:0]       max_gnd_reg, max_gnd_next;
    logic signed [ALT_W-1:0]  max_alt_reg, max_alt_next;
    logic [DIST_W-1:0]        max_dist_reg, max_dist_next;
    logic signed [ALT_W-1:0]  max_halt_reg, max_halt_next;
    logic signed [CURR_W-1:0] max_curr_reg, max_curr_next;
    logic [DACC_W-1:0]        dist_acc_reg, dist_acc_next;
    logic signed [ACC_WIDTH-1:0] fch_reg, fch_next;
    logic signed [ACC_WIDTH-1:0] tch_reg, tch_next;
    logic [TIME_W-1:0]        start_reg, start_next;
    logic [TIME_W-1:0]        end_reg, end_next;
    logic [TIME_W-1:0]        dur_reg;
    logic                     out_valid_reg;

    // Unpacked tick fields.
    logic [SPEED_W-1:0]       gs;
    logic [SPEED_W-1:0]       as;
    logic [THR_W-1:0]         thr;
    logic signed [ALT_W-1:0]  alt;
    logic [HDG_W-1:0]         hdg;
    logic [DIST_W-1:0]        hdist;
    logic signed [ALT_W-1:0]  halt;
    logic                     lock;
    logic signed [CURR_W-1:0] cur;
    logic [TIME_W-1:0]        now;

    logic                     advance;
    logic                     launch_ok;
    logic                     land_ok;
    logic [ALT_W-1:0]         habs;
    logic [DACC_W:0]          dist_sum;

    // Handshake: the compute stage moves when the result slot is free.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            land_thr_reg   <= LAND_THR_RST;
            land_as_reg    <= LAND_AS_RST;
            land_dist_reg  <= LAND_DIST_RST;
            land_alt_reg   <= LAND_ALT_RST;
            launch_thr_reg <= LAUNCH_THR_RST;
            launch_as_reg  <= LAUNCH_AS_RST;
            launch_alt_reg <= LAUNCH_ALT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LAND_THR:   land_thr_reg   <= cfg_data[THR_W-1:0];
                CFG_LAND_AS:    land_as_reg    <= cfg_data;
                CFG_LAND_DIST:  land_dist_reg  <= cfg_data;
                CFG_LAND_ALT:   land_alt_reg   <= cfg_data[14:0];
                CFG_LAUNCH_THR: launch_thr_reg <= cfg_data[THR_W-1:0];
                CFG_LAUNCH_AS:  launch_as_reg  <= cfg_data;
                CFG_LAUNCH_ALT: launch_alt_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata[IN_BITS-1:0];
        end
    end

    // Field unpacking.
    assign gs    = in_data_reg[IN_GS_LSB    +: SPEED_W];
    assign as    = in_data_reg[IN_AS_LSB    +: SPEED_W];
    assign thr   = in_data_reg[IN_THR_LSB   +: THR_W];
    assign alt   = in_data_reg[IN_ALT_LSB   +: ALT_W];
    assign hdg   = in_data_reg[IN_HDG_LSB   +: HDG_W];
    assign hdist = in_data_reg[IN_HDIST_LSB +: DIST_W];
    assign halt  = in_data_reg[IN_HALT_LSB  +: ALT_W];
    assign lock  = in_data_reg[IN_LOCK_LSB];
    assign cur   = in_data_reg[IN_CURR_LSB  +: CURR_W];
    assign now   = in_data_reg[IN_TIME_LSB  +: TIME_W];

    // Launch and landing tests.
    assign launch_ok = lock && (thr > launch_thr_reg) && (as > launch_as_reg)
                       && (halt > launch_alt_reg);
    assign habs      = halt[ALT_W-1] ? ALT_W'(-halt) : ALT_W'(halt);
    assign land_ok   = (thr < land_thr_reg) && (as < land_as_reg)
                       && (hdist < land_dist_reg) && (habs < {1'b0, land_alt_reg});
    assign dist_sum  = {1'b0, dist_acc_reg} + (DACC_W+1)'(gs);

    // Next state for one tick.
    always_comb
    begin
        flying_next   = flying_reg;
        phase_next    = phase_reg;
        dir_next      = dir_reg;
        max_air_next  = max_air_reg;
        max_gnd_next  = max_gnd_reg;
        max_alt_next  = max_alt_reg;
        max_dist_next = max_dist_reg;
        max_halt_next = max_halt_reg;
        max_curr_next = max_curr_reg;
        dist_acc_next = dist_acc_reg;
        fch_next      = fch_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        tch_next      = acc_add(tch_reg, cur);

        if (!flying_reg)
        begin
            // Searching: test for a launch once per search period.
            if (phase_reg >= PHASE_LAST)
            begin
                phase_next = '0;
                if (launch_ok)
                begin
                    dir_next      = DIR_W'(hdg);
                    start_next    = now;
                    max_air_next  = '0;
                    max_gnd_next  = '0;
                    max_alt_next  = '0;
                    max_dist_next = '0;
                    max_halt_next = '0;
                    max_curr_next = '0;
                    fch_next      = '0;
                    flying_next   = 1'b1;
                end
            end
            else
            begin
                phase_next = phase_reg + PHASE_W'(1);
            end
        end
        else
        begin
            // Flying: update sums and peaks, then test for a landing.
            dist_acc_next = dist_sum[DACC_W] ? '1 : dist_sum[DACC_W-1:0];
            fch_next      = acc_add(fch_reg, cur);
            if (as > max_air_reg)    max_air_next  = as;
            if (gs > max_gnd_reg)    max_gnd_next  = gs;
            if (alt > max_alt_reg)   max_alt_next  = alt;
            if (hdist > max_dist_reg) max_dist_next = hdist;
            if (halt > max_halt_reg) max_halt_next = halt;
            if (cur > max_curr_reg)  max_curr_next = cur;
            end_next = now;
            if (land_ok)
            begin
                flying_next = 1'b0;
                dir_next    = NO_DIR;
                phase_next  = '0;
            end
        end
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flying_reg    <= 1'b0;
            phase_reg     <= '0;
            dir_reg       <= NO_DIR;
            max_air_reg   <= '0;
            max_gnd_reg   <= '0;
            max_alt_reg   <= '0;
            max_dist_reg  <= '0;
            max_halt_reg  <= '0;
            max_curr_reg  <= '0;
            dist_acc_reg  <= '0;
            fch_reg       <= '0;
            tch_reg       <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            dur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                flying_reg   <= flying_next;
                phase_reg    <= phase_next;
                dir_reg      <= dir_next;
                max_air_reg  <= max_air_next;
                max_gnd_reg  <= max_gnd_next;
                max_alt_reg  <= max_alt_next;
                max_dist_reg <= max_dist_next;
                max_halt_reg <= max_halt_next;
                max_curr_reg <= max_curr_next;
                dist_acc_reg <= dist_acc_next;
                fch_reg      <= fch_next;
                tch_reg      <= tch_next;
                start_reg    <= start_next;
                end_reg      <= end_next;
                dur_reg      <= end_next - start_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result beat.
    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[OUT_FLY_LSB]                = flying_reg;
        m_axis_tdata[OUT_DIR_LSB   +: DIR_W]     = dir_reg;
        m_axis_tdata[OUT_PAIR_LSB  +: SPEED_W]   = max_air_reg;
        m_axis_tdata[OUT_PGND_LSB  +: SPEED_W]   = max_gnd_reg;
        m_axis_tdata[OUT_PALT_LSB  +: ALT_W]     = max_alt_reg;
        m_axis_tdata[OUT_PDIST_LSB +: DIST_W]    = max_dist_reg;
        m_axis_tdata[OUT_PHALT_LSB +: ALT_W]     = max_halt_reg;
        m_axis_tdata[OUT_PCURR_LSB +: CURR_W]    = max_curr_reg;
        m_axis_tdata[OUT_DACC_LSB  +: DACC_W]    = dist_acc_reg;
        m_axis_tdata[OUT_FCH_LSB   +: ACC_WIDTH] = fch_reg;
        m_axis_tdata[OUT_TCH_LSB   +: ACC_WIDTH] = tch_reg;
        m_axis_tdata[OUT_DUR_LSB   +: TIME_W]    = dur_reg;
    end

endmodule

FILE: design/fst_checker.sv
// Port-level checks on the flight statistics tracker, bound to the top level.
`timescale 1ns / 1ps

module fst_checker #(
    parameter int ACC_WIDTH = fst_pkg::ACC_WIDTH_DEF
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_axis_tready,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [((173 + 2*ACC_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    import fst_pkg::*;

    logic                 flying;
    logic [DIR_W-1:0]     launch_dir;
    logic [DACC_W-1:0]    distance_cm;

    assign flying      = m_axis_tdata[OUT_FLY_LSB];
    assign launch_dir  = m_axis_tdata[OUT_DIR_LSB  +: DIR_W];
    assign distance_cm = m_axis_tdata[OUT_DACC_LSB +: DACC_W];

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Input back-pressure only comes from a stalled, full result side.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // Outside a flight no launch heading is shown.
    a_dir: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !flying |-> launch_dir == NO_DIR)
        else $error("launch heading shown while searching");

    // The distance sum never goes down.
    a_dist: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> distance_cm >= $past(distance_cm))
        else $error("distance sum decreased");

endmodule

bind flight_stats_tracker fst_checker #(.ACC_WIDTH(ACC_WIDTH)) u_fst_checker (.*);
